@@ hdl/cs1bce_pkg.sv @@
package cs1bce_pkg;

    // block geometry
    localparam int DATA_BITS    = 184;
    localparam int PARITY_BITS  = 40;
    localparam int TAIL_BITS    = 4;
    localparam int CODE_IN_BITS = DATA_BITS + PARITY_BITS + TAIL_BITS;
    localparam int OUT_BYTES    = 57;
    localparam int BYTE_BITS    = 8;

    // widths
    localparam int POS_W   = $clog2(CODE_IN_BITS);
    localparam int ROW_W   = $clog2(OUT_BYTES);
    localparam int BCNT_W  = $clog2(BYTE_BITS + 1);

    // code generators and parity polynomial
    localparam logic [4:0]             POLY_A      = 5'h19;
    localparam logic [4:0]             POLY_B      = 5'h1b;
    localparam logic [PARITY_BITS-1:0] PARITY_POLY = 40'h80_0482_0009;

    // read request from the interleave reader to the coded-bit store
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } rd_req_t;

endpackage

@@ hdl/cs1bce_ram.sv @@
module cs1bce_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 228
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cs1bce_emit.sv @@
module cs1bce_emit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [1:0]             ram_q,
    output cs1bce_pkg::rd_req_t    rd_req,
    output logic                   busy,
    output logic                   coded_valid,
    input  logic                   coded_stall,
    output logic [7:0]             coded_byte,
    output logic                   last_byte
);

    localparam logic [cs1bce_pkg::ROW_W-1:0] ROW_LAST =
        cs1bce_pkg::ROW_W'(cs1bce_pkg::OUT_BYTES - 1);
    localparam logic [cs1bce_pkg::BCNT_W-1:0] BCNT_FULL =
        cs1bce_pkg::BCNT_W'(cs1bce_pkg::BYTE_BITS);

    // output position p = 2q + ph, q = 57*a + r; interleave source is
    // coded bit 8*r + {~ph, a}
    logic                            busy_reg, busy_next;
    logic                            ph_reg, ph_next;
    logic [cs1bce_pkg::ROW_W-1:0]    r_reg, r_next;
    logic [1:0]                      a_reg, a_next;
    logic [cs1bce_pkg::BCNT_W-1:0]   iss_reg, iss_next;
    logic [cs1bce_pkg::BCNT_W-1:0]   gat_reg, gat_next;
    logic                            sel_reg, sel_next;
    logic                            rdv_reg, rdv_next;
    logic [7:0]                      asm_reg, asm_next;
    logic [cs1bce_pkg::ROW_W-1:0]    j_reg, j_next;
    logic                            outv_reg, outv_next;
    logic [7:0]                      byte_reg, byte_next;
    logic                            last_reg, last_next;

    logic issue;
    logic load;
    logic rd_bit;

    assign issue  = busy_reg && (iss_reg != BCNT_FULL);
    assign load   = busy_reg && (gat_reg == BCNT_FULL) && (!outv_reg || !coded_stall);
    assign rd_bit = sel_reg ? ram_q[1] : ram_q[0];

    assign rd_req.en   = issue;
    assign rd_req.addr = {r_reg, ~ph_reg, a_reg[1]};

    // reader sequencing and byte assembly
    always_comb
    begin
        busy_next = busy_reg;
        ph_next   = ph_reg;
        r_next    = r_reg;
        a_next    = a_reg;
        iss_next  = iss_reg;
        gat_next  = gat_reg;
        sel_next  = a_reg[0];
        rdv_next  = issue;
        asm_next  = asm_reg;
        j_next    = j_reg;
        outv_next = outv_reg;
        byte_next = byte_reg;
        last_next = last_reg;

        if (start)
        begin
            busy_next = 1'b1;
        end

        // walk the interleave pattern one bit per read
        if (issue)
        begin
            iss_next = iss_reg + 1'b1;
            if (ph_reg)
            begin
                ph_next = 1'b0;
                if (r_reg == ROW_LAST)
                begin
                    r_next = '0;
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            else
            begin
                ph_next = 1'b1;
            end
        end

        // first bit read ends up in bit 0
        if (rdv_reg)
        begin
            asm_next = {rd_bit, asm_reg[7:1]};
            gat_next = gat_reg + 1'b1;
        end

        // output register
        if (load)
        begin
            outv_next = 1'b1;
            byte_next = asm_reg;
            last_next = (j_reg == ROW_LAST);
            gat_next  = '0;
            iss_next  = '0;
            if (j_reg == ROW_LAST)
            begin
                j_next    = '0;
                busy_next = 1'b0;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
        else if (outv_reg && !coded_stall)
        begin
            outv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 1'b0;
            r_reg    <= '0;
            a_reg    <= '0;
            iss_reg  <= '0;
            gat_reg  <= '0;
            rdv_reg  <= 1'b0;
            j_reg    <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
            r_reg    <= r_next;
            a_reg    <= a_next;
            iss_reg  <= iss_next;
            gat_reg  <= gat_next;
            rdv_reg  <= rdv_next;
            j_reg    <= j_next;
            outv_reg <= outv_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        asm_reg  <= asm_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign busy        = busy_reg;
    assign coded_valid = outv_reg;
    assign coded_byte  = byte_reg;
    assign last_byte   = last_reg;

endmodule

@@ hdl/cs1_block_channel_encoder.sv @@
// CS-1 block channel encoder. Feed 23 payload bytes per block (bits used LSB
// first); after the 23rd byte the block emits 57 interleaved coded bytes,
// the last one flagged by last_byte. A single bit-serial engine (40-bit
// parity register plus K=5 rate-1/2 convolutional coder) takes one bit per
// cycle, so each data byte holds data_stall high while its bits are fed to
// the coder after it is taken; no new byte is accepted before then. The 23rd
// byte also runs the 40 parity and 4 tail bits, then the interleaver reads
// the 228 x 2 coded-bit RAM one bit per cycle, pausing after every eight
// bits until the assembled byte can be loaded into the output register
// (held off by coded_stall). Input is stalled until the last coded byte
// sits in the output register. The coded-bit RAM needs no clearing after
// reset: every entry is rewritten before it is read.
module cs1_block_channel_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    output logic       coded_valid,
    input  logic       coded_stall,
    output logic [7:0] coded_byte,
    output logic       last_byte
);

    localparam int POS_W = cs1bce_pkg::POS_W;
    localparam int PAR_W = cs1bce_pkg::PARITY_BITS;

    localparam logic [POS_W-1:0] DATA_LAST = POS_W'(cs1bce_pkg::DATA_BITS - 1);
    localparam logic [POS_W-1:0] PAR_LAST  =
        POS_W'(cs1bce_pkg::DATA_BITS + cs1bce_pkg::PARITY_BITS - 1);
    localparam logic [POS_W-1:0] TAIL_LAST = POS_W'(cs1bce_pkg::CODE_IN_BITS - 1);
    localparam logic [POS_W-1:0] PAR_BASE  = POS_W'(cs1bce_pkg::DATA_BITS);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DATA = 3'd1;
    localparam logic [2:0] ST_PAR  = 3'd2;
    localparam logic [2:0] ST_TAIL = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [POS_W-1:0]  m_reg, m_next;
    logic [7:0]        shift_reg, shift_next;
    logic [PAR_W-1:0]  par_reg, par_next;
    logic [3:0]        hist_reg, hist_next;

    logic              accept;
    logic              active;
    logic              cur_bit;
    logic [POS_W-1:0]  par_pos;
    logic [5:0]        par_idx;
    logic [4:0]        enc_st;
    logic [1:0]        enc_out;
    logic [PAR_W-1:0]  par_shift;
    logic              start;
    logic              emit_busy;
    logic [1:0]        ram_q;

    cs1bce_pkg::rd_req_t rd_req;

    assign data_stall = (state_reg != ST_IDLE);
    assign accept     = data_valid && !data_stall;
    assign active     = (state_reg == ST_DATA) || (state_reg == ST_PAR)
                        || (state_reg == ST_TAIL);

    // parity bits: register bytes MSB byte first, LSB first within a byte
    assign par_pos = m_reg - PAR_BASE;
    assign par_idx = {3'd4 - par_pos[5:3], par_pos[2:0]};

    always_comb
    begin
        unique case (state_reg)
            ST_DATA: cur_bit = shift_reg[0];
            ST_PAR:  cur_bit = par_reg[par_idx];
            default: cur_bit = 1'b0;
        endcase
    end

    // convolutional coder: bit 0 -> coded 2m, bit 1 -> coded 2m+1
    assign enc_st     = {hist_reg, cur_bit};
    assign enc_out[0] = ^(enc_st & cs1bce_pkg::POLY_A);
    assign enc_out[1] = ^(enc_st & cs1bce_pkg::POLY_B);

    // parity register shift with feedback on bit 39
    assign par_shift = {par_reg[PAR_W-2:0], cur_bit};

    assign start = (state_reg == ST_TAIL) && (m_reg == TAIL_LAST);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        shift_next = shift_reg;
        par_next   = par_reg;
        hist_next  = hist_reg;

        if (active)
        begin
            hist_next = enc_st[3:0];
            m_next    = m_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    shift_next = data_byte;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                shift_next = {1'b0, shift_reg[7:1]};
                par_next   = par_shift[PAR_W-1] ? (par_shift ^ cs1bce_pkg::PARITY_POLY)
                                                : par_shift;
                if (m_reg[2:0] == 3'd7)
                begin
                    state_next = (m_reg == DATA_LAST) ? ST_PAR : ST_IDLE;
                end
            end
            ST_PAR:
            begin
                if (m_reg == PAR_LAST)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (m_reg == TAIL_LAST)
                begin
                    m_next     = '0;
                    par_next   = '0;
                    hist_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            m_reg     <= '0;
            par_reg   <= '0;
            hist_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            par_reg   <= par_next;
            hist_reg  <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    // coded-bit store, one pair per coder input bit
    cs1bce_ram #(
        .WIDTH(2),
        .DEPTH(cs1bce_pkg::CODE_IN_BITS)
    ) u_store (
        .clk   (clk),
        .we    (active),
        .waddr (m_reg),
        .wdata (enc_out),
        .re    (rd_req.en),
        .raddr (rd_req.addr),
        .rdata (ram_q)
    );

    // interleave reader and output register
    cs1bce_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .ram_q       (ram_q),
        .rd_req      (rd_req),
        .busy        (emit_busy),
        .coded_valid (coded_valid),
        .coded_stall (coded_stall),
        .coded_byte  (coded_byte),
        .last_byte   (last_byte)
    );

`ifndef NO_ASSERTIONS
    // store is never written while the reader walks it
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(active && rd_req.en))
        else $error("coded-bit store written during interleave read");

    // waiting for a payload byte only on a byte boundary
    a_idle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (m_reg[2:0] == 3'd0))
        else $error("bit position not byte aligned in idle");

    // tail bits flush the coder history before emitting
    a_tail_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (hist_reg == 4'd0))
        else $error("coder history not flushed at end of block");

    // reader is started only when free, and is busy right after
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (!emit_busy ##1 emit_busy))
        else $error("interleave reader start while busy");
`endif

endmodule
